>>> design/bpd_pkg.sv
// Shared types and constants for the binomial 2x pyramid downsampler.
// No dependencies; used by bpd_tap_cell, the top level and the testbench.

package bpd_pkg;

  localparam int PIX_W     = 8;   // pixel width
  localparam int ACC_W     = 12;  // width of a 16-weight tap sum of 8-bit pixels
  localparam int CFG_W     = 11;  // configuration register width
  localparam int CFG_IDX_W = 1;   // configuration register index width
  localparam int W_RESET   = 320; // reset value of out_width
  localparam int H_RESET   = 240; // reset value of out_height

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH  = 1'b0,
    REG_OUT_HEIGHT = 1'b1
  } cfg_reg_t;

  // Control and data carried from the line-store read stage to the vertical stage.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [1:0]       slot;
    logic [PIX_W-1:0] mid;
  } vert_stage_t;

endpackage

>>> design/bpd_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Read-first: a read and a write at the same address return the old word.
// No dependencies.

module bpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/bpd_tap_cell.sv
// One cell of the horizontal filter chain: holds one pixel of the row window,
// passes it to its neighbor and adds its weighted pixel to the running tap sum.
// Depends on bpd_pkg.

module bpd_tap_cell #(
  parameter int WEIGHT = 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [bpd_pkg::PIX_W-1:0] pix_in,
  output logic [bpd_pkg::PIX_W-1:0] pix_out,
  input  logic [bpd_pkg::ACC_W-1:0] acc_in,
  output logic [bpd_pkg::ACC_W-1:0] acc_out
);

  logic [bpd_pkg::PIX_W-1:0] pix_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_in;
    end
  end

  assign pix_out = pix_r;
  assign acc_out = acc_in + bpd_pkg::ACC_W'(WEIGHT) * bpd_pkg::ACC_W'(pix_r);

endmodule

>>> design/binomial_pyramid_downsample_2x.sv
// Top level of the 2x binomial pyramid downsampler.
// Depends on bpd_pkg, bpd_tap_cell and bpd_ram.
//
// Usage: pixels of a 2W x 2H frame enter in raster order on the in_ channel,
// one word per pixel; in_tuser set marks the first pixel of a frame and
// resets the position counters. Frames may also simply follow each other.
// Each input row is filtered horizontally by [1 4 6 4 1]/16 at even columns
// through a chain of four tap cells, and the truncated intermediate value is
// kept in one of four line memories. On even rows the four stored lines and
// the current intermediate value are filtered vertically by the same kernel.
// Only the interior (W-2) x (H-2) of the W x H result is sent on the out_
// channel, in raster order; out_tlast marks the last interior pixel.
// Throughput is one pixel per clock while in_tready is high. A result reaches
// out_tvalid through the line memory read, registered together with the
// vertical stage, and then the output register, which takes the vertical sum.
// When the receiver stalls, input words that produce no result keep flowing;
// in_tready falls only once a result waits in the output register and a
// second one waits behind it in the vertical stage.
// Reset clears the position to row 0, column 0, sets W and H to 320 and 240
// (clamped to the supported range) and empties the pipeline. The line memories
// are not cleared; every entry is written before it is read. The user must
// write W and H on the cfg_ port only when idle; the block doesn't enforce it.

module binomial_pyramid_downsample_2x #(
  parameter int MAX_OUT_WIDTH  = 1024,
  parameter int MAX_OUT_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input pixel stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] pixel
  input  logic                          in_tuser,   // [0] frame_start
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_pixel
  output logic                          out_tlast,  // frame_last
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int WW = $clog2(MAX_OUT_WIDTH + 1);    // holds W
  localparam int HW = $clog2(MAX_OUT_HEIGHT + 1);   // holds H
  localparam int CW = $clog2(2 * MAX_OUT_WIDTH);    // input column
  localparam int RW = $clog2(2 * MAX_OUT_HEIGHT);   // input row
  localparam int KW = $clog2(MAX_OUT_WIDTH);        // intermediate column
  localparam int CMPW = 14;                         // compare width for clamping
  localparam int W_RST = (bpd_pkg::W_RESET > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH :
                         bpd_pkg::W_RESET;
  localparam int H_RST = (bpd_pkg::H_RESET > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT :
                         bpd_pkg::H_RESET;
  localparam int PW = bpd_pkg::PIX_W;
  localparam int AW = bpd_pkg::ACC_W;

  // ---------------------------------------------------------------------------
  // Configuration. Dimensions are clamped when written, so the datapath only
  // ever sees legal values.
  // ---------------------------------------------------------------------------
  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [CMPW-1:0] cfg_ext;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = CMPW'(cfg_data);

  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    if (cfg_valid) begin
      unique case (bpd_pkg::cfg_reg_t'(cfg_index))
        bpd_pkg::REG_OUT_WIDTH: begin
          if (cfg_ext < CMPW'(4)) w_nxt = WW'(4);
          else if (cfg_ext > CMPW'(MAX_OUT_WIDTH)) w_nxt = WW'(MAX_OUT_WIDTH);
          else w_nxt = WW'(cfg_data);
        end
        bpd_pkg::REG_OUT_HEIGHT: begin
          if (cfg_ext < CMPW'(4)) h_nxt = HW'(4);
          else if (cfg_ext > CMPW'(MAX_OUT_HEIGHT)) h_nxt = HW'(MAX_OUT_HEIGHT);
          else h_nxt = HW'(cfg_data);
        end
        default: begin
          w_nxt = w_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WW'(W_RST);
      h_r <= HW'(H_RST);
    end else begin
      w_r <= w_nxt;
      h_r <= h_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Input position. The stored position may lie outside the frame after a
  // dimension change, so it is wrapped once more before use.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic [WW:0]   w2, col_inc;
  logic [HW:0]   h2, row_pre, row_inc;
  logic          in_fire;

  assign w2      = {w_r, 1'b0};
  assign h2      = {h_r, 1'b0};
  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    row_pre = (HW+1)'(row_r);
    if (in_tuser) begin
      col_cur = '0;
      row_cur = '0;
    end else begin
      if ((WW+1)'(col_r) >= w2) begin
        col_cur = '0;
        row_pre = (HW+1)'(row_r) + (HW+1)'(1);
      end else begin
        col_cur = col_r;
      end
      row_cur = (row_pre >= h2) ? '0 : RW'(row_pre);
    end

    col_inc = (WW+1)'(col_cur) + (WW+1)'(1);
    row_inc = (HW+1)'(row_cur) + (HW+1)'(1);
    if (col_inc >= w2) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h2) ? '0 : RW'(row_inc);
    end else begin
      col_nxt = CW'(col_inc);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Horizontal pass: a chain of four tap cells holds the last four pixels of
  // the stream; the incoming pixel enters the sum with weight one. From the
  // newest held pixel to the oldest the weights are 4, 6, 4 and 1.
  // ---------------------------------------------------------------------------
  localparam int TAPS = 4;

  logic [PW-1:0] tap_pix [TAPS+1];
  logic [AW-1:0] tap_acc [TAPS+1];
  logic [PW-1:0] mid;

  assign tap_pix[0] = in_tdata;
  assign tap_acc[0] = AW'(in_tdata);

  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    bpd_tap_cell #(
      .WEIGHT ((i == 1) ? 6 : ((i == 3) ? 1 : 4))
    ) u_cell (
      .clk     (clk),
      .en      (in_fire),
      .pix_in  (tap_pix[i]),
      .pix_out (tap_pix[i+1]),
      .acc_in  (tap_acc[i]),
      .acc_out (tap_acc[i+1])
    );
  end

  assign mid = tap_acc[TAPS][AW-1:4];

  // Column 2k+2 completes intermediate column k, for k in 1..W-2.
  logic          htap, emit, last_px;
  logic [KW-1:0] k;

  assign htap    = !col_cur[0] && (col_cur >= CW'(4)) &&
                   ((WW+1)'(col_cur) + (WW+1)'(2) <= w2);
  assign k       = KW'(col_cur[CW-1:1] - (CW-1)'(1));
  assign emit    = htap && !row_cur[0] && (row_cur >= RW'(4)) &&
                   ((HW+1)'(row_cur) + (HW+1)'(2) <= h2);
  assign last_px = ((HW+1)'(row_cur) + (HW+1)'(2) == h2) &&
                   (WW'(k) + WW'(2) == w_r);

  // ---------------------------------------------------------------------------
  // Line memories: slot = input row mod 4. All four are read at column k in
  // the cycle the word is taken; the slot of row r-4 is rewritten in that
  // same cycle, which the read-first memory resolves.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] line_rd [4];

  for (genvar s = 0; s < 4; s++) begin : g_line
    bpd_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_OUT_WIDTH)
    ) u_line (
      .clk     (clk),
      .wr_en   (in_fire && htap && (row_cur[1:0] == 2'(s))),
      .wr_addr (k),
      .wr_data (mid),
      .rd_en   (in_tready),
      .rd_addr (k),
      .rd_data (line_rd[s])
    );
  end

  // ---------------------------------------------------------------------------
  // Vertical stage and output register. The vertical stage advances whenever
  // it is empty or the output register can take its word, which lets words
  // without results flow past a stalled receiver.
  // ---------------------------------------------------------------------------
  bpd_pkg::vert_stage_t vs_r;
  logic                 out_valid_r;
  logic [PW-1:0]        out_pix_r, out_pix_nxt;
  logic                 out_last_r;
  logic                 out_adv;
  logic [PW-1:0]        va, vb, vc, vd;
  logic [AW-1:0]        vsum;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !vs_r.valid || out_adv;

  // Rows r-4, r-3, r-2 and r-1 sit in slots r, r+1, r+2 and r+3 (mod 4).
  assign va = line_rd[vs_r.slot];
  assign vb = line_rd[vs_r.slot + 2'd1];
  assign vc = line_rd[vs_r.slot + 2'd2];
  assign vd = line_rd[vs_r.slot + 2'd3];

  assign vsum = AW'(6) * AW'(vc) + AW'(4) * (AW'(vb) + AW'(vd)) +
                AW'(va) + AW'(vs_r.mid);
  assign out_pix_nxt = vsum[AW-1:4];

  // Only the valid flags are reset; the data fields follow the handshakes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        vs_r.valid <= in_fire && emit;
      end
      if (out_adv) begin
        out_valid_r <= vs_r.valid;
      end
    end
    if (in_fire) begin
      vs_r.last <= last_px;
      vs_r.slot <= row_cur[1:0];
      vs_r.mid  <= mid;
    end
    if (out_adv) begin
      out_pix_r  <= out_pix_nxt;
      out_last_r <= vs_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // Input may only be held off when both result registers are occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (vs_r.valid && out_valid_r && !out_tready))
    else $error("input stalled while a result stage is free");

  // A result is only produced at an intermediate column inside the line.
  a_emit_col: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (htap && (WW'(k) + WW'(2) <= w_r)))
    else $error("result produced outside the interior columns");

  // An accepted word that produces a result occupies the vertical stage.
  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit) |=> vs_r.valid)
    else $error("result lost entering the vertical stage");

  // A held vertical-stage result moves to the output once the output has room.
  a_vs_move: assert property (@(posedge clk) disable iff (!rst_n)
    (vs_r.valid && out_adv) |=> out_valid_r)
    else $error("vertical-stage result lost at the output register");

  // The stored row never leaves the largest supported frame.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (HW+1)'(row_r) < (HW+1)'(2 * MAX_OUT_HEIGHT))
    else $error("row counter out of range");

endmodule

>>> tb/pyramid_reduce_check.sv
// Checker for the binomial 2x pyramid downsampler: predicts every reduced pixel
// from the words accepted on the in_ and cfg_ channels and compares the out_ channel.
// Depends on bpd_pkg for widths, reset values and register indexes.

module pyramid_reduce_check #(
  parameter int MAX_OUT_WIDTH  = 1024,
  parameter int MAX_OUT_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] pixel
  input  logic                          in_tuser,   // [0] frame_start
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [7:0]                    out_tdata,  // [7:0] out_pixel
  input  logic                          out_tlast,  // frame_last
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpd_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            results_due
);

  typedef struct packed {
    logic [bpd_pkg::PIX_W-1:0] pixel;
    logic                      last;
  } reduced_px_t;

  reduced_px_t               reduced_due[$];
  logic [bpd_pkg::PIX_W-1:0] row_window[4];  // [0] is the newest pixel of the row
  logic [bpd_pkg::PIX_W-1:0] mid_lines[4][MAX_OUT_WIDTH];
  int unsigned               width_reg;
  int unsigned               height_reg;
  int unsigned               col_pos;
  int unsigned               row_pos;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 4) return 4;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic note_failure(string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Horizontal tap at even columns into the line store, vertical tap on even rows.
  task automatic reduce_pixel(logic [7:0] px, logic fs);
    int unsigned w, h, mid, k, v;
    reduced_px_t res;
    w = clamp_dim(width_reg, MAX_OUT_WIDTH);
    h = clamp_dim(height_reg, MAX_OUT_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (col_pos >= 2 * w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= 2 * h) row_pos = 0;
    end
    if (col_pos % 2 == 0 && col_pos >= 4 && col_pos <= 2 * w - 2) begin
      mid = (6 * row_window[1] + 4 * (row_window[0] + row_window[2]) + row_window[3] + px) >> 4;
      k = (col_pos - 2) >> 1;
      if (row_pos % 2 == 0 && row_pos >= 4 && row_pos <= 2 * h - 2) begin
        v = (6 * mid_lines[(row_pos - 2) % 4][k]
             + 4 * (mid_lines[(row_pos - 3) % 4][k] + mid_lines[(row_pos - 1) % 4][k])
             + mid_lines[(row_pos - 4) % 4][k] + mid) >> 4;
        res.pixel = v[7:0];
        res.last  = (row_pos == 2 * h - 2) && (k == w - 2);
        reduced_due.push_back(res);
      end
      mid_lines[row_pos % 4][k] = mid[7:0];
    end
    row_window[3] = row_window[2];
    row_window[2] = row_window[1];
    row_window[1] = row_window[0];
    row_window[0] = px;
    col_pos++;
    if (col_pos >= 2 * w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= 2 * h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reduced_due.delete();
      row_window     = '{default: '0};
      width_reg      = bpd_pkg::W_RESET;
      height_reg     = bpd_pkg::H_RESET;
      col_pos        = 0;
      row_pos        = 0;
      mismatch_count = 0;
    end else begin
      // Compare before predicting: a word accepted at this edge cannot have
      // produced the result leaving at the same edge.
      if (out_tvalid && out_tready) begin
        if (reduced_due.size() == 0) begin
          note_failure($sformatf("result %0d (last %0b) arrived with none due",
                                 out_tdata, out_tlast));
        end else begin
          if (out_tdata !== reduced_due[0].pixel)
            note_failure($sformatf("out_pixel expected %0d, got %0d",
                                   reduced_due[0].pixel, out_tdata));
          if (out_tlast !== reduced_due[0].last)
            note_failure($sformatf("frame_last expected %0b, got %0b",
                                   reduced_due[0].last, out_tlast));
          void'(reduced_due.pop_front());
        end
      end
      if (in_tvalid && in_tready) reduce_pixel(in_tdata, in_tuser);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bpd_pkg::REG_OUT_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
    end
    results_due = reduced_due.size();
  end

endmodule

>>> tb/binomial_pyramid_downsample_2x_tb.sv
// Top of the testbench for the binomial 2x pyramid downsampler: clock, reset,
// stimulus on the in_ and cfg_ channels, the result receiver and the verdict.
// Depends on bpd_pkg, the block itself and pyramid_reduce_check.

module binomial_pyramid_downsample_2x_tb;

  // The longest legitimate silence on all channels is the receiver's long
  // hold plus a few idle gaps; anything far beyond that means a hang.
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  typedef enum {PAT_RANDOM, PAT_MAX, PAT_ALTERNATE} fill_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;   // [7:0] pixel
  logic               in_tuser;   // [0] frame_start
  logic               out_tvalid;
  logic               out_tready;
  logic [7:0]         out_tdata;  // [7:0] out_pixel
  logic               out_tlast;  // frame_last
  logic               cfg_valid;
  logic               cfg_ready;
  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bpd_pkg::CFG_W-1:0]     cfg_data;

  int mismatch_count;
  int results_due;
  int quiet_cycles;
  int hold_asks;
  int holds_done;
  bit idle_on = 1'b1;

  binomial_pyramid_downsample_2x dut (.*);

  pyramid_reduce_check reduce_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result receiver. Every word it waits a random gap before raising
  // out_tready (none when idling is off). When the stimulus asks for it, the
  // receiver first holds off for a long stretch so that the output register
  // and the vertical stage fill and the block has to drop in_tready.
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Offers one pixel word after a random gap and returns at the falling edge
  // that follows its acceptance, with in_tvalid still high.
  task automatic send_word(input logic [7:0] px, input logic fs);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write so that
  // back-to-back writes never lower and raise it in the same step.
  task automatic write_reg(input bpd_pkg::cfg_reg_t idx,
                           input logic [bpd_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // One phase of traffic. A negative width or height keeps that register;
  // if either is to be written, the block is drained first, given a few
  // cycles for words that make no result to leave the pipeline, and then the
  // registers are written. Without a restart the first word carries no
  // frame_start, so the position wraps on its own. Noisy phases drop the odd
  // frame_start into the middle of a frame. A stressed phase asks the
  // receiver for its long hold at the start and, halfway through, stops
  // sending until every predicted result has come back.
  task automatic run_phase(input int w_val, input int h_val, input int words,
                           input bit restart, input fill_t fill, input bit idling,
                           input bit noisy, input bit stress);
    logic [7:0] px;
    logic       fs;
    if (w_val >= 0 || h_val >= 0) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while (results_due != 0) @(negedge clk);
      repeat (4) @(negedge clk);
      if (w_val >= 0) write_reg(bpd_pkg::REG_OUT_WIDTH, w_val[bpd_pkg::CFG_W-1:0]);
      if (h_val >= 0) write_reg(bpd_pkg::REG_OUT_HEIGHT, h_val[bpd_pkg::CFG_W-1:0]);
      cfg_valid <= 1'b0;
    end
    idle_on = idling;
    if (stress) hold_asks++;
    for (int i = 0; i < words; i++) begin
      if (stress && i == words / 2) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (results_due != 0) @(negedge clk);
      end
      case (fill)
        PAT_MAX:       px = 8'hFF;
        PAT_ALTERNATE: px = (i % 2 != 0) ? 8'hFF : 8'h00;
        default: begin
          if ($urandom_range(0, 7) == 0) px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          else px = 8'($urandom_range(0, 255));
        end
      endcase
      fs = (i == 0 && restart) || (noisy && $urandom_range(0, 149) == 0);
      send_word(px, fs);
    end
  endtask

  initial begin
    int w_sel;
    int h_sel;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = bpd_pkg::REG_OUT_WIDTH;
    cfg_data   = '0;
    rst_n      = 1'b0;
    hold_asks  = 0;
    holds_done = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset dimensions, 640 x 480 input: the first pixels of row zero make
    // no result.
    run_phase(-1, -1, 16, 1'b1, PAT_RANDOM, 1'b1, 1'b0, 1'b0);

    // Narrowest width under the reset height: rows four and six already
    // yield reduced pixels, none of them the last of the frame.
    run_phase(4, -1, 56, 1'b1, PAT_RANDOM, 1'b1, 1'b0, 1'b0);

    // Both dimensions below the minimum, so both clamp to 4. One frame of
    // all-ones pixels, then a second frame of alternating black and white
    // that starts without frame_start and relies on the wrap at frame end.
    run_phase(0, 3, 64, 1'b1, PAT_MAX, 1'b1, 1'b0, 1'b0);
    run_phase(-1, -1, 64, 1'b0, PAT_ALTERNATE, 1'b1, 1'b0, 1'b0);

    // Width 2047 clamps to the maximum width. No idling here. The phase
    // stops inside row zero, beyond the row length of the next phase.
    run_phase(2047, 4, 40, 1'b1, PAT_RANDOM, 1'b0, 1'b0, 1'b0);

    // Height 2047 clamps to the maximum at the narrowest width, entered
    // without frame_start: the column wraps to the next row. Eight rows
    // follow, so the position ends on row nine.
    run_phase(4, 2047, 64, 1'b0, PAT_RANDOM, 1'b1, 1'b0, 1'b0);

    // Height shrinks under the current row: the row wraps to zero.
    run_phase(4, 4, 40, 1'b0, PAT_RANDOM, 1'b1, 1'b1, 1'b0);

    // A random small frame with random content.
    w_sel = $urandom_range(4, 6);
    h_sel = $urandom_range(4, 5);
    run_phase(w_sel, h_sel, 4 * w_sel * h_sel + $urandom_range(0, 2 * w_sel),
              1'b1, PAT_RANDOM, 1'b1, 1'b1, 1'b0);

    // Back-pressure: long receiver hold, then a sender pause mid-phase.
    run_phase(6, 5, 120, 1'b1, PAT_RANDOM, 1'b1, 1'b1, 1'b1);

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    // A few more cycles so that a stray extra result would still be caught.
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> binomial_pyramid_downsample_2x.f
design/bpd_pkg.sv
design/bpd_ram.sv
design/bpd_tap_cell.sv
design/binomial_pyramid_downsample_2x.sv
tb/pyramid_reduce_check.sv
tb/binomial_pyramid_downsample_2x_tb.sv
